>>> rtl/sip_pkg.sv
// Shared types and constants for the segment intersection point block.
// No dependencies; used by the front end, the queue and the back end.
package sip_pkg;

  // Depth of the queue between the classification front end and the divider back end.
  localparam int QUEUE_DEPTH = 4;

  // Outcome of classification, carried with every request.
  typedef struct packed {
    logic crosses;
    logic shared_end;
  } class_t;

endpackage

>>> rtl/segment_intersection_point.sv
// Segment intersection point: takes two 2-D segments per request and returns one result per
// request, in order. A new request is taken every cycle while the result side keeps up. Each
// request passes, in order, three front stages that work out the endpoint matches and the
// orientation cross products, a four-entry queue, and a back end that spends three stages on
// the numerator product and operand magnitudes, one stage per quotient bit in the restoring
// divider (COORD_BITS + 1 bits) and one output register. The queue lets the front keep
// accepting while the back is held.
// Depends on sip_front, sip_queue and sip_back.
module segment_intersection_point #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  first_start_x,
  input  logic signed [COORD_BITS-1:0]  first_start_y,
  input  logic signed [COORD_BITS-1:0]  first_end_x,
  input  logic signed [COORD_BITS-1:0]  first_end_y,
  input  logic signed [COORD_BITS-1:0]  second_start_x,
  input  logic signed [COORD_BITS-1:0]  second_start_y,
  input  logic signed [COORD_BITS-1:0]  second_end_x,
  input  logic signed [COORD_BITS-1:0]  second_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          crosses,
  output logic signed [COORD_BITS-1:0]  cross_x,
  output logic signed [COORD_BITS-1:0]  cross_y,
  output logic                          shared_end,
  output logic                          collinear
);

  localparam int QW = 8 * COORD_BITS + 10;

  logic          f_valid, q_full, q_push, q_pop, q_not_empty;
  logic [QW-1:0] f_data, q_data;

  // Classification front end.
  sip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_start_x  (first_start_x),
    .first_start_y  (first_start_y),
    .first_end_x    (first_end_x),
    .first_end_y    (first_end_y),
    .second_start_x (second_start_x),
    .second_start_y (second_start_y),
    .second_end_x   (second_end_x),
    .second_end_y   (second_end_y),
    .out_valid      (f_valid),
    .out_full       (q_full),
    .out_data       (f_data)
  );

  assign q_push = f_valid && !q_full;

  // Queue between the two halves.
  sip_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (f_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // Division back end.
  sip_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_not_empty),
    .in_pop     (q_pop),
    .in_data    (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .crosses    (crosses),
    .cross_x    (cross_x),
    .cross_y    (cross_y),
    .shared_end (shared_end),
    .collinear  (collinear)
  );

`ifndef SYNTHESIS
  // A rejected pair reports nothing but zeros.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !crosses |-> cross_x == '0 && cross_y == '0 && !shared_end && !collinear)
    else $error("rejected pair carries a non-zero result");

  // A shared endpoint and a collinear hit never come together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(shared_end && collinear))
    else $error("shared_end and collinear both set");

  // Either qualifier implies a hit.
  a_flag_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (shared_end || collinear) |-> crosses)
    else $error("qualifier set without a hit");

  // The queue is never written while full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full && !q_pop |=> !(q_full && $past(q_push)))
    else $error("queue written while full");
`endif

endmodule

>>> rtl/sip_front.sv
// Front end: endpoint comparison and the four orientation cross products.
// Depends on sip_pkg; feeds sip_queue.
module sip_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  first_start_x,
  input  logic signed [COORD_BITS-1:0]  first_start_y,
  input  logic signed [COORD_BITS-1:0]  first_end_x,
  input  logic signed [COORD_BITS-1:0]  first_end_y,
  input  logic signed [COORD_BITS-1:0]  second_start_x,
  input  logic signed [COORD_BITS-1:0]  second_start_y,
  input  logic signed [COORD_BITS-1:0]  second_end_x,
  input  logic signed [COORD_BITS-1:0]  second_end_y,
  output logic                          out_valid,
  input  logic                          out_full,
  output logic [8*COORD_BITS+9:0]       out_data
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int ZW = 2 * COORD_BITS + 3;

  logic adv;
  logic v1, v2, v3;

  // Stage one registers
  logic                 sh1, sel1;
  logic [COORD_BITS-1:0] px1, py1;
  logic signed [DW-1:0] dax1, day1, dbx1, dby1, e1x1, e1y1, e2x1, e2y1;
  logic signed [DW-1:0] g1x1, g1y1, g2x1, g2y1;

  // Stage two registers
  logic                 sh2;
  logic [COORD_BITS-1:0] px2, py2;
  logic signed [DW-1:0] dax2, day2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5, p6, p7;

  // Stage three registers
  sip_pkg::class_t      cls3;
  logic [COORD_BITS-1:0] px3, py3;
  logic signed [DW-1:0] dax3, day3;
  logic signed [ZW-1:0] z13, z23;

  // Combinational values
  logic                 eq11, eq12, eq21, eq22, shared_c;
  logic signed [ZW-1:0] o1, o2, z1, z2;
  logic                 side_a, side_b;

  // The whole front pipeline moves together unless its last stage is blocked.
  assign adv      = !v3 || !out_full;
  assign in_ready = adv;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Endpoint equality tests.
  always_comb begin
    eq11 = (first_start_x == second_start_x) && (first_start_y == second_start_y);
    eq12 = (first_start_x == second_end_x) && (first_start_y == second_end_y);
    eq21 = (first_end_x == second_start_x) && (first_end_y == second_start_y);
    eq22 = (first_end_x == second_end_x) && (first_end_y == second_end_y);
    shared_c = eq11 || eq12 || eq21 || eq22;
  end

  // Stage one: coordinate differences and the reported point.
  always_ff @(posedge clk) begin
    if (adv) begin
      sh1  <= shared_c;
      sel1 <= shared_c && !(eq11 || eq12);
      px1  <= (shared_c && !(eq11 || eq12)) ? first_end_x : first_start_x;
      py1  <= (shared_c && !(eq11 || eq12)) ? first_end_y : first_start_y;
      dax1 <= DW'(first_end_x) - DW'(first_start_x);
      day1 <= DW'(first_end_y) - DW'(first_start_y);
      dbx1 <= DW'(second_end_x) - DW'(second_start_x);
      dby1 <= DW'(second_end_y) - DW'(second_start_y);
      e1x1 <= DW'(second_start_x) - DW'(first_start_x);
      e1y1 <= DW'(second_start_y) - DW'(first_start_y);
      e2x1 <= DW'(second_end_x) - DW'(first_start_x);
      e2y1 <= DW'(second_end_y) - DW'(first_start_y);
      g1x1 <= DW'(first_start_x) - DW'(second_start_x);
      g1y1 <= DW'(first_start_y) - DW'(second_start_y);
      g2x1 <= DW'(first_end_x) - DW'(second_start_x);
      g2y1 <= DW'(first_end_y) - DW'(second_start_y);
    end
  end

  // Stage two: the eight cross-product terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      sh2  <= sh1 || sel1;
      px2  <= px1;
      py2  <= py1;
      dax2 <= dax1;
      day2 <= day1;
      p0   <= PW'(dax1) * PW'(e1y1);
      p1   <= PW'(day1) * PW'(e1x1);
      p2   <= PW'(dax1) * PW'(e2y1);
      p3   <= PW'(day1) * PW'(e2x1);
      p4   <= PW'(dbx1) * PW'(g1y1);
      p5   <= PW'(dby1) * PW'(g1x1);
      p6   <= PW'(dbx1) * PW'(g2y1);
      p7   <= PW'(dby1) * PW'(g2x1);
    end
  end

  // Orientations and the two same-side rejections.
  always_comb begin
    o1 = ZW'(p0) - ZW'(p1);
    o2 = ZW'(p2) - ZW'(p3);
    z1 = ZW'(p4) - ZW'(p5);
    z2 = ZW'(p6) - ZW'(p7);
    side_a = (o1 != '0) && (o2 != '0) && (o1[ZW-1] == o2[ZW-1]);
    side_b = (z1 != '0) && (z2 != '0) && (z1[ZW-1] == z2[ZW-1]);
  end

  // Stage three: classification.
  always_ff @(posedge clk) begin
    if (adv) begin
      cls3.shared_end <= sh2;
      cls3.crosses    <= sh2 || !(side_a || side_b);
      px3  <= px2;
      py3  <= py2;
      dax3 <= dax2;
      day3 <= day2;
      z13  <= z1;
      z23  <= z2;
    end
  end

  assign out_data = {cls3, px3, py3, dax3, day3, z13, z23};

endmodule

>>> rtl/sip_queue.sv
// Small first-in first-out queue between the front end and the back end.
// Depends on sip_pkg for its depth.
module sip_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = $clog2(sip_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] store [sip_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(sip_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/sip_back.sv
// Back end: numerator product, pipelined restoring divider and final offset.
// Depends on sip_pkg; takes requests from sip_queue.
module sip_back #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_pop,
  input  logic [8*COORD_BITS+9:0]       in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          crosses,
  output logic signed [COORD_BITS-1:0]  cross_x,
  output logic signed [COORD_BITS-1:0]  cross_y,
  output logic                          shared_end,
  output logic                          collinear
);

  localparam int N  = COORD_BITS;
  localparam int DW = N + 1;
  localparam int ZW = 2 * N + 3;
  localparam int UW = 2 * N + 4;
  localparam int NW = 3 * N + 4;
  localparam int LW = N + 2;
  localparam int HW = ZW - LW;
  localparam int MW = 2 * N + 4;

  typedef struct packed {
    logic          crosses;
    logic          shared_end;
    logic          colin;
    logic [N-1:0]  px;
    logic [N-1:0]  py;
    logic          negx;
    logic          negy;
    logic [UW-1:0] uden;
  } meta_t;

  logic adv;

  // Unpacked queue entry
  sip_pkg::class_t      cls_in;
  logic [N-1:0]         px_in, py_in;
  logic signed [DW-1:0] dax_in, day_in;
  logic signed [ZW-1:0] z1_in, z2_in;

  assign {cls_in, px_in, py_in, dax_in, day_in, z1_in, z2_in} = in_data;

  // Stage B1 registers
  logic                 v1;
  sip_pkg::class_t      cls1;
  logic [N-1:0]         px1, py1;
  logic signed [UW-1:0] den1;
  logic signed [MW-1:0] plox1, ploy1, phix1, phiy1;

  // Stage B2 registers
  logic                 v2;
  sip_pkg::class_t      cls2;
  logic                 colin2;
  logic [N-1:0]         px2, py2;
  logic signed [NW-1:0] numx2, numy2;
  logic [UW-1:0]        uden2;
  logic                 dsign2;

  // Divider stages; index zero is the operand stage
  logic                 dv [N+2];
  meta_t                dm [N+2];
  logic [NW-1:0]        rx [N+2];
  logic [NW-1:0]        ry [N+2];
  logic [N:0]           qx [N+2];
  logic [N:0]           qy [N+2];

  logic                 ov;
  logic signed [ZW-1:0] zlo_ext;
  logic signed [MW-1:0] zhi_ext;

  // The back pipeline moves whenever the output register is free or being emptied.
  assign adv       = !ov || out_ready;
  assign in_pop    = adv && in_valid;
  assign out_valid = ov;

  // Split z1 into an unsigned low part and a signed high part for two narrow products.
  always_comb begin
    zlo_ext = ZW'({1'b0, z1_in[LW-1:0]});
    zhi_ext = MW'(signed'(z1_in[ZW-1:LW]));
  end

  // Stage B1: denominator and partial products of the numerator.
  always_ff @(posedge clk) begin
    if (adv) begin
      cls1  <= cls_in;
      px1   <= px_in;
      py1   <= py_in;
      den1  <= UW'(z1_in) - UW'(z2_in);
      plox1 <= MW'(dax_in) * MW'(zlo_ext);
      ploy1 <= MW'(day_in) * MW'(zlo_ext);
      phix1 <= MW'(dax_in) * zhi_ext;
      phiy1 <= MW'(day_in) * zhi_ext;
    end
  end

  // Stage B2: full numerators, collinear test and denominator magnitude.
  always_ff @(posedge clk) begin
    if (adv) begin
      cls2   <= cls1;
      colin2 <= cls1.crosses && !cls1.shared_end && (den1 == '0);
      px2    <= px1;
      py2    <= py1;
      numx2  <= (NW'(phix1) <<< LW) + NW'(plox1);
      numy2  <= (NW'(phiy1) <<< LW) + NW'(ploy1);
      uden2  <= den1[UW-1] ? UW'(-den1) : UW'(den1);
      dsign2 <= den1[UW-1];
    end
  end

  // Stage B3: numerator magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    if (adv) begin
      dm[0].crosses    <= cls2.crosses;
      dm[0].shared_end <= cls2.shared_end;
      dm[0].colin      <= colin2;
      dm[0].px         <= px2;
      dm[0].py         <= py2;
      dm[0].negx       <= numx2[NW-1] ^ dsign2;
      dm[0].negy       <= numy2[NW-1] ^ dsign2;
      dm[0].uden       <= uden2;
      rx[0]            <= numx2[NW-1] ? NW'(-numx2) : NW'(numx2);
      ry[0]            <= numy2[NW-1] ? NW'(-numy2) : NW'(numy2);
      qx[0]            <= '0;
      qy[0]            <= '0;
    end
  end

  // Valid bits of the whole back pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      dv[0] <= 1'b0;
    end else if (adv) begin
      v1    <= in_pop;
      v2    <= v1;
      dv[0] <= v2;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k <= N; k++) begin : g_div
    localparam int SH = N - k;
    logic [NW-1:0] dsh;
    logic          takex, takey;

    always_comb begin
      dsh   = {{N{1'b0}}, dm[k].uden} << SH;
      takex = (rx[k] >= dsh);
      takey = (ry[k] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dm[k+1] <= dm[k];
        rx[k+1] <= takex ? rx[k] - dsh : rx[k];
        ry[k+1] <= takey ? ry[k] - dsh : ry[k];
        qx[k+1] <= qx[k] | ((N+1)'(takex) << SH);
        qy[k+1] <= qy[k] | ((N+1)'(takey) << SH);
      end
    end
  end

  // Output register: the reported point for each outcome.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= dv[N+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crosses    <= dm[N+1].crosses;
      shared_end <= dm[N+1].crosses && dm[N+1].shared_end;
      collinear  <= dm[N+1].colin;
      if (!dm[N+1].crosses) begin
        cross_x <= '0;
        cross_y <= '0;
      end else if (dm[N+1].shared_end || dm[N+1].colin) begin
        cross_x <= dm[N+1].px;
        cross_y <= dm[N+1].py;
      end else begin
        cross_x <= dm[N+1].negx ? dm[N+1].px - qx[N+1][N-1:0]
                                : dm[N+1].px + qx[N+1][N-1:0];
        cross_y <= dm[N+1].negy ? dm[N+1].py - qy[N+1][N-1:0]
                                : dm[N+1].py + qy[N+1][N-1:0];
      end
    end
  end

endmodule
